@@ sv/volume_weighted_moving_average_unit_macros.svh @@
// ---------------------------------------------------------------------------
// VWMA assertion macros
// Concurrent assertion shorthands sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VOLUME_WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define VOLUME_WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH

// condition must hold at every edge
`define VWMA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define VWMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/vwma_pkg.sv @@
// ---------------------------------------------------------------------------
// vwma_pkg
// Shared constants, controller states and control/status bundles for the VWMA.
// ---------------------------------------------------------------------------
`default_nettype none

package vwma_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 9;   // window register width
  localparam int PRICE_W    = 24;
  localparam int VOL_W      = 24;
  localparam int PROD_W     = PRICE_W + VOL_W;
  localparam int WSUM_W     = 56;
  localparam int VSUM_W     = 32;
  localparam int QUO_W      = 24;  // quotient bits, one per divider step
  localparam int DCNT_W     = $clog2(QUO_W);
  localparam int LEN_RESET  = 20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CHECK,
    S_DIV,
    S_OUT
  } vwma_state_t;

  typedef struct packed {
    logic accept;    // take request, write history, read evicted bar
    logic mul;       // form new and evicted products
    logic sum;       // update running sums
    logic div_init;  // load divider
    logic div_step;  // one restoring step
    logic load_out;  // load output register
  } vwma_cmd_t;

  typedef struct packed {
    logic emit;       // window is full after this bar
    logic vsum_zero;  // volume sum is zero
    logic div_last;   // final divider step
    logic out_free;   // output register can take a result
  } vwma_sts_t;

endpackage

`default_nettype wire

@@ sv/vwma_ctrl.sv @@
// ---------------------------------------------------------------------------
// vwma_ctrl
// Sequencer: one request at a time; mul, sum, check; if full, divide, output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "volume_weighted_moving_average_unit_macros.svh"

module vwma_ctrl
  import vwma_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output vwma_cmd_t      cmd,
  input  wire vwma_sts_t sts
);

  vwma_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.emit) begin
          state_nxt = S_IDLE;
        end else if (sts.vsum_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `VWMA_ASSERT_NXT(a_accept_to_mul, cmd.accept, state_r == S_MUL, "accept did not start multiply")
  `VWMA_ASSERT_NXT(a_div_end, (state_r == S_DIV) && sts.div_last, state_r == S_OUT,
                   "divider end did not reach output")
  `VWMA_ASSERT_NXT(a_fill_skip, (state_r == S_CHECK) && !sts.emit, state_r == S_IDLE,
                   "filling bar did not return to idle")

endmodule

`default_nettype wire

@@ sv/vwma_dp.sv @@
// ---------------------------------------------------------------------------
// vwma_dp
// History memories, running sums, radix-2 divider and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "volume_weighted_moving_average_unit_macros.svh"

module vwma_dp
  import vwma_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vwma_cmd_t          cmd,
  output vwma_sts_t               sts,
  input  wire logic               cfg_wr,
  input  wire logic [LEN_W-1:0]   cfg_len,
  input  wire logic [PRICE_W-1:0] in_price,
  input  wire logic [VOL_W-1:0]   in_vol,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PRICE_W-1:0]      out_avg,
  output logic                    out_fallback
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WINDOW);

  logic [PRICE_W-1:0] price_mem [MAX_WINDOW];
  logic [VOL_W-1:0]   vol_mem   [MAX_WINDOW];

  logic [LEN_W-1:0]   win_len_r;
  logic [LEN_W-1:0]   len_act;
  logic [LEN_W-1:0]   bars_r, bars_nxt;
  logic [IDX_W-1:0]   wr_pos_r;
  logic [IDX_W-1:0]   old_idx;
  logic               evict_r, emit_r;

  logic [PRICE_W-1:0] price_r, old_price_r;
  logic [VOL_W-1:0]   vol_r, old_vol_r;
  logic [PROD_W-1:0]  new_prod_r, old_prod_r;
  logic [VOL_W-1:0]   old_vol_q_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [VSUM_W-1:0]  vsum_r;

  logic [VSUM_W-1:0]  rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [VSUM_W:0]    trial;
  logic [VSUM_W:0]    trial_sub;

  logic               out_valid_r;
  logic [PRICE_W-1:0] out_avg_r;
  logic               out_flag_r;

  // zero acts as one bar, oversize saturates to the built depth
  always_comb begin
    if (win_len_r == '0) begin
      len_act = LEN_W'(1);
    end else if (win_len_r > MaxLen) begin
      len_act = MaxLen;
    end else begin
      len_act = win_len_r;
    end
  end

  assign old_idx  = wr_pos_r - len_act[IDX_W-1:0];
  assign bars_nxt = (bars_r < len_act) ? bars_r + LEN_W'(1) : bars_r;

  // history: write newest, read evicted bar in the same edge (old data)
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price_mem[wr_pos_r] <= in_price;
      vol_mem[wr_pos_r]   <= in_vol;
      old_price_r         <= price_mem[old_idx];
      old_vol_r           <= vol_mem[old_idx];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= LEN_W'(LEN_RESET);
      bars_r    <= '0;
      wr_pos_r  <= '0;
      wsum_r    <= '0;
      vsum_r    <= '0;
      evict_r   <= 1'b0;
      emit_r    <= 1'b0;
    end else if (cfg_wr) begin
      win_len_r <= cfg_len;
      bars_r    <= '0;
      wr_pos_r  <= '0;
      wsum_r    <= '0;
      vsum_r    <= '0;
    end else begin
      if (cmd.accept) begin
        evict_r  <= (bars_r >= len_act);
        emit_r   <= (bars_nxt >= len_act);
        bars_r   <= bars_nxt;
        wr_pos_r <= wr_pos_r + IDX_W'(1);
      end
      if (cmd.sum) begin
        wsum_r <= wsum_r + WSUM_W'(new_prod_r) - WSUM_W'(old_prod_r);
        vsum_r <= vsum_r + VSUM_W'(vol_r) - VSUM_W'(old_vol_q_r);
      end
    end
  end

  // payload: request capture and products
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price_r <= in_price;
      vol_r   <= in_vol;
    end
    if (cmd.mul) begin
      new_prod_r  <= price_r * vol_r;
      old_prod_r  <= evict_r ? old_price_r * old_vol_r : '0;
      old_vol_q_r <= evict_r ? old_vol_r : '0;
    end
  end

  // restoring divider, quotient fits QUO_W bits so the top of the sum
  // already sits below the divisor
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign trial_sub = trial - {1'b0, vsum_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= wsum_r[WSUM_W-1:QUO_W];
      quo_r  <= wsum_r[QUO_W-1:0];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial_sub[VSUM_W]) begin
        rem_r <= trial_sub[VSUM_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[VSUM_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_avg_r  <= sts.vsum_zero ? price_r : quo_r;
      out_flag_r <= sts.vsum_zero;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_avg      = out_avg_r;
  assign out_fallback = out_flag_r;

  assign sts.emit      = emit_r;
  assign sts.vsum_zero = (vsum_r == '0);
  assign sts.div_last  = (dcnt_r == DCNT_W'(QUO_W - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  `VWMA_ASSERT_IMP(a_zero_vol_sum, vsum_r == '0, wsum_r == '0,
                   "weighted sum nonzero with zero volume")
  `VWMA_ASSERT(a_bars_bound, bars_r <= len_act, "bar count beyond window")
  `VWMA_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_r || out_ready,
                   "output overwritten while pending")

endmodule

`default_nettype wire

@@ sv/volume_weighted_moving_average_unit.sv @@
// ---------------------------------------------------------------------------
// volume_weighted_moving_average_unit
// Sliding-window VWMA over market bars, Q16.8 prices, one result per bar once full.
// ---------------------------------------------------------------------------
// Each input request is one bar: in_tdata[23:0] close price (unsigned Q16.8),
// in_tdata[47:24] volume. The last window_length bars (1..256, reset 20; 0 acts
// as 1, above 256 saturates) sit in two 256-entry history memories next to
// running sums of price*volume (56 b) and volume (32 b). Until the window is
// full a bar produces no result. After that each bar produces one result:
// out_tdata = sum(price*volume) / sum(volume), truncated, Q16.8, with
// out_tuser = 0; if the volume sum is zero the newest close is sent instead
// with out_tuser = 1. A write on the cfg channel loads the window length and
// restarts filling (sums, write pointer and bar count cleared); write it only
// while the block is idle. cfg_ready is always high.
// Sequencing: one request at a time. A bar that yields an average passes, from
// acceptance to the next possible acceptance, through capture and memory access,
// multiply, sum update, check, the radix-2 restoring divider (one quotient bit
// per cycle) and the output load. A filling bar returns to idle after the check;
// a zero-volume bar skips the divider. The output register lets the next bar be
// accepted while a result still waits; a stall on out_tready only holds the
// block when the next result is ready to load. The history memories have no
// reset; only entries written since the last restart are ever used.
// ---------------------------------------------------------------------------
`default_nettype none

module volume_weighted_moving_average_unit
  import vwma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // bar input
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [47:0]       in_tdata,   // [23:0] close_price, [47:24] volume_amount
  // result output
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,  // [23:0] average_price
  output logic                   out_tuser,  // [0] zero_volume_fallback
  // window length register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [LEN_W-1:0]  cfg_data    // window_length
);

  vwma_cmd_t cmd;
  vwma_sts_t sts;
  logic      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  vwma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vwma_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr       (cfg_wr),
    .cfg_len      (cfg_data),
    .in_price     (in_tdata[PRICE_W-1:0]),
    .in_vol       (in_tdata[PRICE_W+VOL_W-1:PRICE_W]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_avg      (out_tdata),
    .out_fallback (out_tuser)
  );

endmodule

`default_nettype wire
